// ===== rtl/sepf_pkg.sv =====
package sepf_pkg;

  localparam int CNT_W     = 10;
  localparam int LBL_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // reset values of the hangover lengths
  localparam logic [CNT_W-1:0] LEADER_RST  = CNT_W'(5);
  localparam logic [CNT_W-1:0] TRAILER_RST = CNT_W'(10);
  localparam logic [CNT_W-1:0] CANCEL_RST  = CNT_W'(5);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEADER  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CANCEL  = CFG_IDX_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_LEADER  = 3'd1,
    ST_CANCEL  = 3'd2,
    ST_SPEECH  = 3'd3,
    ST_TRAILER = 3'd4
  } state_t;

  typedef enum logic [LBL_W-1:0] {
    LBL_SILENCE = 2'd0,
    LBL_MAYBE   = 2'd1,
    LBL_SPEECH  = 2'd2
  } label_t;

  typedef struct packed {
    logic [CNT_W-1:0] leader;
    logic [CNT_W-1:0] trailer;
    logic [CNT_W-1:0] cancel;
  } hang_cfg_t;

endpackage

// ===== rtl/sepf_cfg.sv =====
module sepf_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sepf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sepf_pkg::CFG_DAT_W-1:0]      cfg_wdata,
  output sepf_pkg::hang_cfg_t                 hang
);
  import sepf_pkg::*;

  hang_cfg_t hang_r;
  hang_cfg_t hang_nxt;

  always_comb begin
    hang_nxt = hang_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_LEADER:  hang_nxt.leader  = cfg_wdata[CNT_W-1:0];
        REG_TRAILER: hang_nxt.trailer = cfg_wdata[CNT_W-1:0];
        REG_CANCEL:  hang_nxt.cancel  = cfg_wdata[CNT_W-1:0];
        default:     hang_nxt = hang_r;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hang_r.leader  <= LEADER_RST;
      hang_r.trailer <= TRAILER_RST;
      hang_r.cancel  <= CANCEL_RST;
    end else begin
      hang_r <= hang_nxt;
    end
  end

  assign hang = hang_r;

endmodule

// ===== rtl/sepf_fsm.sv =====
module sepf_fsm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                owner,
  input  sepf_pkg::hang_cfg_t hang,
  output sepf_pkg::label_t    label
);
  import sepf_pkg::*;

  state_t           state_r;
  state_t           state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] cnt_inc;
  logic             leader_hit;
  logic             trailer_hit;
  logic             cancel_hit;

  // saturating run count, compared after the bump
  assign cnt_inc     = (cnt_r == CNT_MAX) ? CNT_MAX : cnt_r + CNT_ONE;
  assign leader_hit  = (cnt_inc >= hang.leader);
  assign trailer_hit = (cnt_inc >= hang.trailer);
  assign cancel_hit  = (cnt_inc >= hang.cancel);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_LEADER: begin
        if (owner) begin
          cnt_nxt = cnt_inc;
          if (leader_hit) state_nxt = ST_SPEECH;
        end else begin
          state_nxt = ST_CANCEL;
          cnt_nxt   = CNT_ONE;
        end
      end
      ST_CANCEL: begin
        if (owner) begin
          state_nxt = ST_LEADER;
          cnt_nxt   = CNT_ONE;
        end else begin
          cnt_nxt = cnt_inc;
          if (cancel_hit) state_nxt = ST_IDLE;
        end
      end
      ST_SPEECH: begin
        if (!owner) begin
          state_nxt = ST_TRAILER;
          cnt_nxt   = CNT_ONE;
        end
      end
      ST_TRAILER: begin
        if (owner) begin
          state_nxt = ST_SPEECH;
        end else begin
          cnt_nxt = cnt_inc;
          if (trailer_hit) state_nxt = ST_IDLE;
        end
      end
      default: begin
        if (owner) begin
          state_nxt = ST_LEADER;
          cnt_nxt   = CNT_ONE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    case (state_r)
      ST_LEADER:  label = (owner && leader_hit) ? LBL_SPEECH : LBL_MAYBE;
      ST_CANCEL:  label = (!owner && cancel_hit) ? LBL_SILENCE : LBL_MAYBE;
      ST_SPEECH:  label = LBL_SPEECH;
      ST_TRAILER: label = (!owner && trailer_hit) ? LBL_SILENCE : LBL_SPEECH;
      default:    label = owner ? LBL_MAYBE : LBL_SILENCE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else if (step) begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/speech_endpoint_fsm.sv =====
// Speech endpointer with hangover.
// Input channel (in_valid / in_stall / in_is_owner): one item per audio frame,
// the flag is high when the frame was classified as the owner speaker.
// Result channel (out_valid / out_stall / out_endpoint_label): one item per
// input item, in order: 0 silence, 1 maybe speech, 2 speech.
// Config port (cfg_we / cfg_index / cfg_wdata): index 0 leader, 1 trailer,
// 2 cancel hangover length in frames; write only while no item is in flight.
// Path: an accepted item is captured in the input register, then moves with
// the state update into the result register once that register is free.
// Throughput: one item per cycle while the receiver does not stall.
// Reset (synchronous, rst_n low): state idle, run count zero, lengths
// 5 / 10 / 5, both pipeline registers empty.
// When the receiver stalls, the result register holds; the input register
// still fills, and in_stall rises once it holds an item behind the stalled
// result register.
module speech_endpoint_fsm (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_is_owner,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sepf_pkg::LBL_W-1:0]          out_endpoint_label,
  input  logic                                cfg_we,
  input  logic [sepf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sepf_pkg::CFG_DAT_W-1:0]      cfg_wdata
);
  import sepf_pkg::*;

  hang_cfg_t         hang;
  label_t            label;

  // input register
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic              s1_owner_r;

  // result register
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [LBL_W-1:0]  out_label_r;

  logic              out_free;  // result register can take a new item
  logic              step;      // item moves from input to result register
  logic              in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !step);
  assign out_valid_nxt = step || (out_valid_r && out_stall);

  sepf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .hang      (hang)
  );

  // state and run count advance only when an item moves forward
  sepf_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .owner (s1_owner_r),
    .hang  (hang),
    .label (label)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) s1_owner_r  <= in_is_owner;
    if (step)    out_label_r <= label;
  end

  assign out_valid          = out_valid_r;
  assign out_endpoint_label = out_label_r;

  // back-pressure only when both registers hold an item and output is stalled
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("in_stall raised while pipeline has room");

  // a waiting item with an empty result register must move on
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("item stuck in input register");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("pipeline not empty after reset");

  // the result register never holds a code outside the label set
  a_label_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_label_r <= LBL_SPEECH))
    else $error("illegal endpoint label");

endmodule

// ===== verif/speech_endpoint_fsm_tb.sv =====
`timescale 1ns / 1ps

module speech_endpoint_fsm_tb;
  import sepf_pkg::*;

  // index that decodes to no register; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
  localparam int LONG_HOLD_CYCLES = 60;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_is_owner = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [LBL_W-1:0]     out_endpoint_label;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  speech_endpoint_fsm dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_is_owner       (in_is_owner),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_endpoint_label(out_endpoint_label),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Endpointer model: own copy of hangover lengths, state and run counter.
  // ---------------------------------------------------------------------------
  hang_cfg_t        hang_lengths = '{leader: LEADER_RST, trailer: TRAILER_RST,
                                     cancel: CANCEL_RST};
  state_t           ep_state = ST_IDLE;
  logic [CNT_W-1:0] run_len = '0;

  bit                   pending_frames[$];   // owner flags still to be sent
  label_t               expected_labels[$];  // labels owed by the block, oldest first
  logic [CFG_IDX_W-1:0] cfg_idx_q[$];
  logic [CFG_DAT_W-1:0] cfg_dat_q[$];

  int mismatches = 0;
  int idle_pct = 0;         // chance per cycle that an idle burst starts (both sides)
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  int hold_reqs = 0;        // bumped by the stimulus to ask for a long receiver hold
  int holds_done = 0;

  // run counter saturates at all ones, never wraps
  function automatic logic [CNT_W-1:0] bump_run(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? CNT_MAX : c + CNT_ONE;
  endfunction

  // advance the model by one frame and return the label it owes
  function automatic label_t next_endpoint_label(input logic owner);
    label_t lbl;
    case (ep_state)
      ST_LEADER: begin
        if (owner) begin
          run_len = bump_run(run_len);
          if (run_len >= hang_lengths.leader) begin
            ep_state = ST_SPEECH;
            lbl = LBL_SPEECH;
          end else begin
            lbl = LBL_MAYBE;
          end
        end else begin
          ep_state = ST_CANCEL;
          run_len = CNT_ONE;
          lbl = LBL_MAYBE;
        end
      end
      ST_CANCEL: begin
        if (owner) begin
          ep_state = ST_LEADER;
          run_len = CNT_ONE;
          lbl = LBL_MAYBE;
        end else begin
          run_len = bump_run(run_len);
          if (run_len >= hang_lengths.cancel) begin
            ep_state = ST_IDLE;
            lbl = LBL_SILENCE;
          end else begin
            lbl = LBL_MAYBE;
          end
        end
      end
      ST_SPEECH: begin
        if (!owner) begin
          ep_state = ST_TRAILER;
          run_len = CNT_ONE;
        end
        lbl = LBL_SPEECH;
      end
      ST_TRAILER: begin
        if (owner) begin
          ep_state = ST_SPEECH;
          lbl = LBL_SPEECH;
        end else begin
          run_len = bump_run(run_len);
          if (run_len >= hang_lengths.trailer) begin
            ep_state = ST_IDLE;
            lbl = LBL_SILENCE;
          end else begin
            lbl = LBL_SPEECH;
          end
        end
      end
      default: begin
        // idle, and any stray code behaves as idle
        if (owner) begin
          ep_state = ST_LEADER;
          run_len = CNT_ONE;
          lbl = LBL_MAYBE;
        end else begin
          ep_state = ST_IDLE;
          lbl = LBL_SILENCE;
        end
      end
    endcase
    return lbl;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: pops owner flags from pending_frames, random idle bursts between.
  // Accepted item -> model steps and the owed label is queued.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : frame_driver
    logic nv;
    logic nb;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      nb = in_is_owner;
      if (in_valid && !in_stall) begin
        expected_labels.push_back(next_endpoint_label(in_is_owner));
        nv = 1'b0;
      end
      if (!nv) begin
        nb = 1'($urandom_range(0, 1));   // payload is don't-care while idle
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_frames.size() != 0) begin
          if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            send_gap = $urandom_range(1, 8) - 1;
          end else begin
            nv = 1'b1;
            nb = pending_frames.pop_front();
          end
        end
      end
      in_valid <= nv;
      in_is_owner <= nb;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: random bursts, plus an occasional long hold so the two
  // pipeline registers fill and in_stall has to rise.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : label_stall
    logic ns;
    ns = 1'b0;
    if (rst_n) begin
      if (hold_reqs != holds_done) begin
        holds_done++;
        hold_left = LONG_HOLD_CYCLES - 1;
        ns = 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        ns = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        ns = 1'b1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 8) - 1;
        ns = 1'b1;
      end
    end
    out_stall <= ns;
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted label against the oldest owed one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : label_monitor
    label_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_labels.size() == 0) begin
        $display("%0t: unexpected label, expected none, actual %0d",
                 $realtime, out_endpoint_label);
        mismatches++;
      end else begin
        want = expected_labels.pop_front();
        if (out_endpoint_label !== want) begin
          $display("%0t: endpoint_label mismatch, expected %0d, actual %0d",
                   $realtime, want, out_endpoint_label);
          mismatches++;
        end
      end
    end
  end

  task automatic push_frames(input bit owner, input int n);
    repeat (n) pending_frames.push_back(owner);
  endtask

  // stimulus waits until every frame is sent and every owed label has come back
  task automatic wait_drained();
    while (pending_frames.size() != 0 || in_valid || expected_labels.size() != 0)
      @(posedge clk);
  endtask

  task automatic queue_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_idx_q.push_back(idx);
    cfg_dat_q.push_back(CFG_DAT_W'(val));
  endtask

  // called at a clock edge with the block idle; one write per cycle
  task automatic write_regs();
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] dat;
    while (cfg_idx_q.size() != 0) begin
      idx = cfg_idx_q.pop_front();
      dat = cfg_dat_q.pop_front();
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= dat;
      case (idx)
        REG_LEADER:  hang_lengths.leader = dat;
        REG_TRAILER: hang_lengths.trailer = dat;
        REG_CANCEL:  hang_lengths.cancel = dat;
        default: ;
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg_wdata <= CFG_DAT_W'($urandom_range(0, 1023));
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(0, 12);
    if (r < 9) return $urandom_range(0, 40);
    return $urandom_range(0, 1023);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int phase_pct[8];
    int added;
    int span;
    phase_pct = '{25, 10, 0, 40, 25, 15, 30, 0};

    idle_pct = 20;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset lengths 5/10/5: silence, leader to speech, trailer broken by an
    // owner frame, trailer to idle, then leader -> cancel -> idle
    push_frames(1'b0, 2);
    push_frames(1'b1, 6);
    push_frames(1'b0, 3);
    push_frames(1'b1, 1);
    push_frames(1'b0, 10);
    push_frames(1'b1, 2);
    push_frames(1'b0, 5);
    wait_drained();

    // zero and one lengths: move on the first incrementing frame
    for (int len = 0; len < 2; len++) begin
      queue_reg(REG_LEADER, len);
      queue_reg(REG_TRAILER, len);
      queue_reg(REG_CANCEL, len);
      write_regs();
      push_frames(1'b1, 2);
      push_frames(1'b0, 2);
      push_frames(1'b1, 1);
      push_frames(1'b0, 2);
      wait_drained();
    end

    // random phases: mostly well-formed owner / non-owner runs around the
    // hangover lengths, some single-frame noise
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) begin
        // longest lengths with short runs that never reach them, then
        // medium lengths with runs that do; no idling here
        idle_pct = 0;
        queue_reg(REG_UNUSED, $urandom_range(0, 1023));
        queue_reg(REG_LEADER, 1023);
        queue_reg(REG_TRAILER, 1023);
        queue_reg(REG_CANCEL, 1023);
        write_regs();
        push_frames(1'b1, 20);
        push_frames(1'b0, 20);
        wait_drained();
        queue_reg(REG_LEADER, 40);
        queue_reg(REG_TRAILER, 40);
        queue_reg(REG_CANCEL, 40);
        write_regs();
        push_frames(1'b1, 41);
        push_frames(1'b0, 40);
        push_frames(1'b1, 1);
        push_frames(1'b0, 40);
        wait_drained();
      end
      idle_pct = phase_pct[ph];
      if (ph == 3) queue_reg(REG_UNUSED, 0);
      queue_reg(REG_LEADER, pick_length());
      queue_reg(REG_TRAILER, pick_length());
      queue_reg(REG_CANCEL, pick_length());
      write_regs();
      added = 0;
      while (added < 35) begin
        if ($urandom_range(0, 4) == 0) begin
          push_frames(1'($urandom_range(0, 1)), 1);
          added++;
        end else begin
          span = $urandom_range(1, (hang_lengths.leader > 58) ? 60 :
                                int'(hang_lengths.leader) + 2);
          push_frames(1'b1, span);
          added += span;
          span = (hang_lengths.trailer > hang_lengths.cancel) ?
                 int'(hang_lengths.trailer) : int'(hang_lengths.cancel);
          span = $urandom_range(1, (span > 58) ? 60 : span + 2);
          push_frames(1'b0, span);
          added += span;
        end
      end
      // receiver stops while the sender keeps offering
      if (ph == 1 || ph == 4) hold_reqs++;
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_labels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
